/* sv/twnm_pkg.sv */
// ----------------------------------------------------------------------------
// twnm_pkg
// Shared types, constants and helpers for the time-window nearest-match buffer.
// ----------------------------------------------------------------------------
package twnm_pkg;

	localparam int DEPTH       = 128;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int STAMP_W     = 48;
	localparam int WORD_W      = 32;
	localparam int MAXE_W      = 8;
	localparam int LIM_W       = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] WINDOW_RESET = WORD_W'(5000000);
	localparam logic [MAXE_W-1:0] MAXE_RESET   = MAXE_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW      = 1'b0,
		CFG_MAX_ENTRIES = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	typedef struct packed {
		logic [STAMP_W-1:0]       stamp;
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] theta;
	} entry_t;

	typedef struct packed {
		action_t action;
		entry_t  data;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic [CNT_W-1:0] entry_count;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EV_RD,
		ST_EV_CHK,
		ST_SCAN,
		ST_RESULT
	} state_t;

	function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(DEPTH))
			sum = sum - (CNT_W + 1)'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

endpackage

/* sv/twnm_if.sv */
// ----------------------------------------------------------------------------
// twnm_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface twnm_req_if;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [47:0]              stamp_us;
	logic                     has_pose;
	logic signed [31:0]       pose_x;
	logic signed [31:0]       pose_y;
	logic signed [31:0]       pose_theta;

	modport source (output valid, action, stamp_us, has_pose, pose_x, pose_y, pose_theta,
		input ready);
	modport sink (input valid, action, stamp_us, has_pose, pose_x, pose_y, pose_theta,
		output ready);
endinterface

interface twnm_rsp_if;
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic [47:0]              match_stamp_us;
	logic signed [31:0]       out_x;
	logic signed [31:0]       out_y;
	logic signed [31:0]       out_theta;

	modport source (output valid, found, match_stamp_us, out_x, out_y, out_theta,
		input ready);
	modport sink (input valid, found, match_stamp_us, out_x, out_y, out_theta,
		output ready);
endinterface

/* sv/twnm_front.sv */
// ----------------------------------------------------------------------------
// twnm_front
// Accepts request words, drops inserts without a pose, forwards the rest.
// ----------------------------------------------------------------------------
module twnm_front
	import twnm_pkg::*;
(
	twnm_req_if.sink   req,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	assign req.ready = !q_full;

	always_comb begin
		push_cmd.action     = action_t'(req.action);
		push_cmd.data.stamp = req.stamp_us;
		push_cmd.data.x     = req.pose_x;
		push_cmd.data.y     = req.pose_y;
		push_cmd.data.theta = req.pose_theta;
		push = req.valid && !q_full && (req.action == ACT_LOOKUP || req.has_pose);
	end

endmodule

/* sv/twnm_queue.sv */
// ----------------------------------------------------------------------------
// twnm_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module twnm_queue
	import twnm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

/* sv/twnm_back.sv */
// ----------------------------------------------------------------------------
// twnm_back
// Ring store, eviction sequencer, nearest-stamp scan and result register.
// ----------------------------------------------------------------------------
module twnm_back
	import twnm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  q_head_t               head,
	output logic                  pop,
	twnm_rsp_if.source            rsp,
	output stat_t                 stat
);

	entry_t              mem_q [DEPTH];
	entry_t              rd_data_s1;
	logic                rd_v_s1;

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    oldest_q;
	logic [CNT_W-1:0]    count_q;
	logic [STAMP_W-1:0]  newest_q;
	logic [WORD_W-1:0]   window_q;
	logic [MAXE_W-1:0]   max_entries_q;

	logic [STAMP_W-1:0]  ref_q;
	logic [IDX_W-1:0]    scan_addr_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    issued_q;
	logic                first_q;
	logic [STAMP_W-1:0]  best_diff_q;
	entry_t              best_q;

	logic                out_v_q;
	logic                found_q;
	entry_t              out_q;

	logic [IDX_W-1:0]    rd_addr;
	logic                mem_we;
	logic [IDX_W-1:0]    wr_slot;
	logic                issue;
	logic                evict;
	logic                span_wide;
	logic                over_lim;
	logic [LIM_W-1:0]    lim;
	logic [STAMP_W-1:0]  diff;
	logic                take;
	logic                out_load;

	// count limit clamped to 1..DEPTH
	always_comb begin
		if (max_entries_q == '0)
			lim = LIM_W'(1);
		else if (LIM_W'(max_entries_q) > LIM_W'(DEPTH))
			lim = LIM_W'(DEPTH);
		else
			lim = LIM_W'(max_entries_q);
	end

	always_comb begin
		span_wide = (newest_q >= rd_data_s1.stamp) &&
			((newest_q - rd_data_s1.stamp) > STAMP_W'(window_q));
		over_lim  = LIM_W'(count_q) > lim;
		diff      = (rd_data_s1.stamp > ref_q) ? rd_data_s1.stamp - ref_q
			: ref_q - rd_data_s1.stamp;
		take      = first_q || (diff < best_diff_q);
		wr_slot   = idx_add(oldest_q, count_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid)
					state_d = (head.cmd.action == ACT_LOOKUP) ? ST_SCAN : ST_EV_RD;
			end
			ST_EV_RD:  state_d = ST_EV_CHK;
			ST_EV_CHK: begin
				if (!evict)
					state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (!issue && !rd_v_s1)
					state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		mem_we   = 1'b0;
		issue    = 1'b0;
		evict    = 1'b0;
		out_load = 1'b0;
		rd_addr  = oldest_q;
		unique case (state_q)
			ST_IDLE: begin
				pop    = head.valid;
				mem_we = head.valid && head.cmd.action == ACT_INSERT;
			end
			ST_EV_RD: rd_addr = oldest_q;
			ST_EV_CHK: begin
				evict   = (count_q > CNT_W'(1)) && (span_wide || over_lim);
				rd_addr = idx_inc(oldest_q);
			end
			ST_SCAN: begin
				issue   = issued_q != total_q;
				rd_addr = scan_addr_q;
			end
			ST_RESULT: out_load = !out_v_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[wr_slot] <= head.cmd.data;
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			oldest_q      <= '0;
			count_q       <= '0;
			window_q      <= WINDOW_RESET;
			max_entries_q <= MAXE_RESET;
			rd_v_s1       <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cfg_wen) begin
				unique case (cfg_reg_t'(cfg_idx))
					CFG_WINDOW:      window_q      <= cfg_data[WORD_W-1:0];
					CFG_MAX_ENTRIES: max_entries_q <= cfg_data[MAXE_W-1:0];
					default: ;
				endcase
			end
			if (mem_we) begin
				// full ring: overwrite oldest
				if (count_q == CNT_W'(DEPTH))
					oldest_q <= idx_inc(oldest_q);
				else
					count_q <= count_q + CNT_W'(1);
			end else if (evict) begin
				oldest_q <= idx_inc(oldest_q);
				count_q  <= count_q - CNT_W'(1);
			end
			if (out_load)
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			newest_q <= head.cmd.data.stamp;
		if (state_q == ST_IDLE && head.valid && head.cmd.action == ACT_LOOKUP) begin
			ref_q    <= head.cmd.data.stamp;
			issued_q <= '0;
			first_q  <= 1'b1;
			if (count_q == '0) begin
				total_q     <= '0;
				scan_addr_q <= oldest_q;
			end else if (head.cmd.data.stamp == '0) begin
				total_q     <= CNT_W'(1);
				scan_addr_q <= idx_add(oldest_q, count_q - CNT_W'(1));
			end else begin
				total_q     <= count_q;
				scan_addr_q <= oldest_q;
			end
		end else begin
			if (issue) begin
				issued_q    <= issued_q + CNT_W'(1);
				scan_addr_q <= idx_inc(scan_addr_q);
			end
			if (rd_v_s1) begin
				first_q <= 1'b0;
				if (take) begin
					best_diff_q <= diff;
					best_q      <= rd_data_s1;
				end
			end
		end
		if (out_load) begin
			found_q <= total_q != '0;
			out_q   <= (total_q != '0) ? best_q : '0;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.found          = found_q;
	assign rsp.match_stamp_us = out_q.stamp;
	assign rsp.out_x          = out_q.x;
	assign rsp.out_y          = out_q.y;
	assign rsp.out_theta      = out_q.theta;
	assign stat.entry_count   = count_q;

endmodule

/* sv/time_window_nearest_match_buffer.sv */
// ----------------------------------------------------------------------------
// time_window_nearest_match_buffer
// Ring of timestamped Q16.16 poses with window eviction and nearest lookup.
// ----------------------------------------------------------------------------
// req carries inserts (action 0) and lookups (action 1); rsp returns one
// word per lookup, none per insert. Inserts without a pose are dropped at
// the input. Configuration goes through cfg_wen/cfg_idx/cfg_data:
// index 0 window_us, index 1 max_entries.
// A two-word command queue sits between input and the store sequencer, so
// req keeps taking words while a result waits on rsp.
// Insert: the store write, then the eviction read and check, once per evicted entry.
// Lookup: a scan of entry_count entries before rsp.valid (reference time
// zero: the newest entry only; empty store: none); the store has one read
// port and the scan reads one entry per cycle; each command ends before the next pops.
// Reset empties the store and loads window_us 5000000, max_entries 100.
// A stalled rsp holds its word; the sequencer then waits in its result
// state and the queue fills before req.ready drops.
// ----------------------------------------------------------------------------
module time_window_nearest_match_buffer
	import twnm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	twnm_req_if.sink              req,
	twnm_rsp_if.source            rsp,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic    push;
	cmd_t    push_cmd;
	logic    q_full;
	logic    pop;
	q_head_t head;
	stat_t   stat;

	twnm_front u_front (
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	twnm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head)
	);

	twnm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.head     (head),
		.pop      (pop),
		.rsp      (rsp),
		.stat     (stat)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.entry_count <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(stat.entry_count) <= (CNT_W + 1)'($past(stat.entry_count)) + 1'b1)
		else $error("entry count grew by more than one");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.match_stamp_us == '0 && rsp.out_x == '0 &&
			rsp.out_y == '0 && rsp.out_theta == '0)
		else $error("not-found word carries data");
`endif

endmodule

/* test/tb_time_window_nearest_match_buffer.sv */
// ----------------------------------------------------------------------------
// tb_time_window_nearest_match_buffer
// Self-checking bench for the timestamped pose ring with nearest-time lookup.
// ----------------------------------------------------------------------------
// A directed sequence covers the empty store, dropped readings, ties, stamps
// that go backwards and extreme values. Random phases then run with several
// window and entry-limit settings, including an overfull ring and a long
// stall on the response side. A scoreboard predicts each lookup result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_time_window_nearest_match_buffer
	import twnm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 400;
	localparam int IDLE_PCT      = 36;

	typedef struct packed {
		action_t action;
		logic    has_pose;
		entry_t  entry;
	} req_word_t;

	typedef struct packed {
		logic   found;
		entry_t entry;
	} match_t;

	class pose_ring_model;
		entry_t            ring[DEPTH];
		int unsigned       head;
		int unsigned       fill;
		logic [WORD_W-1:0] window_us;
		logic [MAXE_W-1:0] max_entries;
		match_t            expected_matches[$];
		int unsigned       errors;

		function new();
			head = 0;
			fill = 0;
			window_us = WINDOW_RESET;
			max_entries = MAXE_RESET;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
			case (r)
				CFG_WINDOW: window_us = v[WORD_W-1:0];
				CFG_MAX_ENTRIES: max_entries = v[MAXE_W-1:0];
				default: ;
			endcase
		endfunction

		function entry_t slot_entry(int unsigned k);
			return ring[(head + k) % DEPTH];
		endfunction

		function void drop_oldest();
			head = (head + 1) % DEPTH;
			fill--;
		endfunction

		function bit span_too_wide();
			logic [STAMP_W-1:0] lo;
			logic [STAMP_W-1:0] hi;
			lo = slot_entry(0).stamp;
			hi = slot_entry(fill - 1).stamp;
			if (hi < lo)
				return 1'b0;
			return (hi - lo) > STAMP_W'(window_us);
		endfunction

		function void store_reading(entry_t e);
			int unsigned lim;
			lim = max_entries;
			if (lim < 1)
				lim = 1;
			if (lim > DEPTH)
				lim = DEPTH;
			if (fill == DEPTH)
				drop_oldest();
			ring[(head + fill) % DEPTH] = e;
			fill++;
			while (fill > 1 && (span_too_wide() || fill > lim))
				drop_oldest();
		endfunction

		function match_t nearest(logic [STAMP_W-1:0] ref_stamp);
			match_t             m;
			int unsigned        best;
			int unsigned        k;
			logic [STAMP_W-1:0] s;
			logic [STAMP_W-1:0] d;
			logic [STAMP_W-1:0] best_d;
			m = '0;
			if (fill == 0)
				return m;
			best = 0;
			best_d = '0;
			if (ref_stamp == '0) begin
				best = fill - 1;
			end else begin
				for (k = 0; k < fill; k++) begin
					s = slot_entry(k).stamp;
					d = (s > ref_stamp) ? s - ref_stamp : ref_stamp - s;
					if (k == 0 || d < best_d) begin
						best_d = d;
						best = k;
					end
				end
			end
			m.found = 1'b1;
			m.entry = slot_entry(best);
			return m;
		endfunction

		function void take_request(req_word_t w);
			if (w.action == ACT_LOOKUP)
				expected_matches = {expected_matches, nearest(w.entry.stamp)};
			else if (w.has_pose)
				store_reading(w.entry);
		endfunction

		function void check_match(match_t got);
			match_t want;
			if (expected_matches.size() == 0) begin
				$error("response word with no lookup pending");
				errors++;
				return;
			end
			want = expected_matches[0];
			expected_matches.delete(0);
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				errors++;
			end
			if (got.entry.stamp !== want.entry.stamp) begin
				$error("match_stamp_us: expected %0d, got %0d", want.entry.stamp,
					got.entry.stamp);
				errors++;
			end
			if (got.entry.x !== want.entry.x) begin
				$error("out_x: expected %0d, got %0d", want.entry.x, got.entry.x);
				errors++;
			end
			if (got.entry.y !== want.entry.y) begin
				$error("out_y: expected %0d, got %0d", want.entry.y, got.entry.y);
				errors++;
			end
			if (got.entry.theta !== want.entry.theta) begin
				$error("out_theta: expected %0d, got %0d", want.entry.theta,
					got.entry.theta);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit                    no_idle = 1'b0;
	bit                    hold_req = 1'b0;
	logic [STAMP_W-1:0]    stamp_now = '0;
	pose_ring_model        sb;

	twnm_req_if req();
	twnm_rsp_if rsp();

	time_window_nearest_match_buffer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [STAMP_W-1:0] rand_stamp();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	task automatic offer(input action_t a, input logic [STAMP_W-1:0] s, input logic hp,
			input logic signed [WORD_W-1:0] px, py, pt);
		req_word_t w;
		w.action = a;
		w.has_pose = hp;
		w.entry.stamp = s;
		w.entry.x = px;
		w.entry.y = py;
		w.entry.theta = pt;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= a;
		req.stamp_us <= s;
		req.has_pose <= hp;
		req.pose_x <= px;
		req.pose_y <= py;
		req.pose_theta <= pt;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.take_request(w);
	endtask

	// inserts leave no trace on rsp, so give any queued ones time to finish
	task automatic drain();
		req.valid <= 1'b0;
		while (sb.expected_matches.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [WORD_W-1:0] win, input logic [MAXE_W-1:0] maxe);
		cfg_wen <= 1'b1;
		cfg_idx <= CFG_WINDOW;
		cfg_data <= CFG_DATA_W'(win);
		@(posedge clk);
		cfg_idx <= CFG_MAX_ENTRIES;
		cfg_data <= CFG_DATA_W'(maxe);
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_reg(CFG_WINDOW, CFG_DATA_W'(win));
		sb.set_reg(CFG_MAX_ENTRIES, CFG_DATA_W'(maxe));
	endtask

	task automatic run_directed();
		offer(ACT_LOOKUP, '0, 1'b0, '0, '0, '0);
		offer(ACT_LOOKUP, 48'd12345, 1'b1, -32'sd1, -32'sd1, -32'sd1);
		offer(ACT_INSERT, 48'd500, 1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		offer(ACT_LOOKUP, '0, 1'b0, '0, '0, '0);
		offer(ACT_INSERT, 48'd1000, 1'b1, 32'sh7fffffff, 32'sh80000000, -32'sd1);
		offer(ACT_INSERT, 48'd1010, 1'b1, 32'sh80000000, 32'sh7fffffff, '0);
		// equal distance to both: older entry must win
		offer(ACT_LOOKUP, 48'd1005, 1'b0, '0, '0, '0);
		offer(ACT_LOOKUP, '0, 1'b0, '0, '0, '0);
		offer(ACT_LOOKUP, 48'hffff_ffff_ffff, 1'b1, '0, '0, '0);
		offer(ACT_LOOKUP, 48'd1, 1'b0, '0, '0, '0);
		offer(ACT_INSERT, 48'd900, 1'b1, 32'sd1, 32'sd2, 32'sd3);
		offer(ACT_LOOKUP, '0, 1'b0, '0, '0, '0);
		offer(ACT_LOOKUP, 48'd950, 1'b0, '0, '0, '0);
		offer(ACT_INSERT, 48'd1000, 1'b1, 32'sd4, 32'sd5, 32'sd6);
		offer(ACT_LOOKUP, 48'd1000, 1'b0, '0, '0, '0);
		offer(ACT_INSERT, 48'hffff_ffff_ffff, 1'b1, -32'sd7, 32'sd8, -32'sd9);
		offer(ACT_LOOKUP, '0, 1'b0, '0, '0, '0);
		offer(ACT_INSERT, '0, 1'b1, 32'sd10, -32'sd11, 32'sd12);
		offer(ACT_LOOKUP, '0, 1'b0, '0, '0, '0);
		offer(ACT_LOOKUP, 48'd1, 1'b0, '0, '0, '0);
		offer(ACT_LOOKUP, 48'h8000_0000_0000, 1'b0, '0, '0, '0);
		drain();
	endtask

	task automatic run_phase(input logic [WORD_W-1:0] win, input logic [MAXE_W-1:0] maxe,
			input int n, input int ins_pct, input int unsigned max_step);
		int                 i;
		int                 roll;
		int                 pick;
		int unsigned        k;
		logic [STAMP_W-1:0] s;
		logic [STAMP_W:0]   sum;
		write_regs(win, maxe);
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < ins_pct) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					stamp_now = stamp_now - STAMP_W'($urandom_range(0, max_step));
				else if (pick < 5)
					stamp_now = rand_stamp();
				else
					stamp_now = stamp_now + STAMP_W'($urandom_range(0, max_step));
				offer(ACT_INSERT, stamp_now, 1'b1, $urandom(), $urandom(), $urandom());
			end else if (roll < ins_pct + 8) begin
				offer(ACT_INSERT, rand_stamp(), 1'b0, $urandom(), $urandom(), $urandom());
			end else begin
				pick = $urandom_range(0, 99);
				s = rand_stamp();
				if (pick < 12) begin
					s = '0;
				end else if (pick < 50) begin
					if (sb.fill > 0) begin
						k = $urandom_range(0, sb.fill - 1);
						s = sb.slot_entry(k).stamp + STAMP_W'($urandom_range(0, 6))
							- STAMP_W'(3);
					end
				end else if (pick < 65) begin
					if (sb.fill > 1) begin
						k = $urandom_range(0, sb.fill - 2);
						sum = {1'b0, sb.slot_entry(k).stamp}
							+ {1'b0, sb.slot_entry(k + 1).stamp};
						s = sum[STAMP_W:1];
					end
				end else if (pick < 90) begin
					s = stamp_now + STAMP_W'($urandom_range(0, 2 * max_step))
						- STAMP_W'(max_step);
				end
				offer(ACT_LOOKUP, s, 1'($urandom()), $urandom(), $urandom(), $urandom());
			end
		end
		drain();
	endtask

	initial begin : rsp_side
		int     hold_left;
		match_t got;
		hold_left = 0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.found = rsp.found;
				got.entry.stamp = rsp.match_stamp_us;
				got.entry.x = rsp.out_x;
				got.entry.y = rsp.out_y;
				got.entry.theta = rsp.out_theta;
				sb.check_match(got);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[time_window_nearest_match_buffer] ERROR");
		$finish;
	end

	initial begin : main
		sb = new();
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.action <= ACT_INSERT;
		req.stamp_us <= '0;
		req.has_pose <= 1'b0;
		req.pose_x <= '0;
		req.pose_y <= '0;
		req.pose_theta <= '0;
		cfg_wen <= 1'b0;
		cfg_idx <= CFG_WINDOW;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(32'd5000000, 8'd100, 250, 55, 120000);
		run_phase(32'd0, 8'd1, 150, 55, 2);
		// ring overfills here; the response side also stalls for a long stretch
		hold_req = 1'b1;
		run_phase(32'hffff_ffff, 8'd255, 300, 70, 20000000);
		run_phase(32'd20000, 8'd0, 150, 55, 5000);
		no_idle = 1'b1;
		run_phase(32'hffff_ffff, 8'd128, 250, 65, 1000);
		no_idle = 1'b0;
		run_phase(32'd300000, 8'd37, 350, 55, 20000);

		if (sb.errors == 0)
			$display("[time_window_nearest_match_buffer] OK");
		else
			$display("[time_window_nearest_match_buffer] ERROR");
		$finish;
	end

endmodule
